FILE: sv/u8u16_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
package u8u16_pkg;

  // One input transfer: a raw UTF-8 byte and the end-of-string flag.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       string_end;
  } in_item_t;

  // One output transfer: a UTF-16 code unit and the last-unit flag.
  typedef struct packed {
    logic [15:0] code_unit;
    logic        run_last;
  } out_item_t;

  // Decode jobs handed from the front to the back.
  typedef enum logic [2:0] {
    OP_ASCII1,  // one unit: bytes[0]
    OP_ASCII2,  // two units: bytes[0], bytes[1]
    OP_DEC2,    // two-byte sequence: lead in bytes[0]
    OP_DEC3,    // three-byte sequence
    OP_DEC4     // four-byte sequence, leaves as a surrogate pair
  } op_t;

  typedef struct packed {
    op_t             kind;
    logic [3:0][7:0] bytes;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

  localparam logic [15:0] SURR_HIGH = 16'hD800;
  localparam logic [15:0] SURR_LOW  = 16'hDC00;
  // 0x10000 seen from bit 10 up
  localparam logic [15:0] SUPP_BASE_K = 16'h0040;

endpackage

FILE: sv/u8u16_front.sv
// Front end: takes bytes, tracks the pending sequence, and issues decode jobs.
module u8u16_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  u8u16_pkg::in_item_t item,
  output u8u16_pkg::push_t    push
);

  logic [7:0] lead;
  logic [7:0] lead_next;
  logic [1:0] need;
  logic [1:0] need_next;
  logic [1:0] seen;
  logic [1:0] seen_next;
  logic [7:0] held [2];
  logic       hold_en;
  logic [7:0] b;
  logic [1:0] b_need;

  function automatic logic [1:0] lead_need(input logic [7:0] c);
    logic [1:0] n;
    case (c) inside
      [8'hC0:8'hDF]: n = 2'd1;
      [8'hE0:8'hEF]: n = 2'd2;
      [8'hF0:8'hF7]: n = 2'd3;
      default:       n = 2'd0;
    endcase
    return n;
  endfunction

  assign b      = item.in_byte;
  assign b_need = lead_need(b);

  always_comb begin
    push       = '0;
    push.entry.kind = u8u16_pkg::OP_ASCII1;
    lead_next  = lead;
    need_next  = need;
    seen_next  = seen;
    hold_en    = 1'b0;
    if (accept) begin
      if (need != 2'd0) begin
        if ({1'b0, seen} + 3'd1 >= {1'b0, need}) begin
          // sequence complete
          push.valid          = 1'b1;
          push.entry.bytes[0] = lead;
          case (need)
            2'd1: begin
              push.entry.kind     = u8u16_pkg::OP_DEC2;
              push.entry.bytes[1] = b;
            end
            2'd2: begin
              push.entry.kind     = u8u16_pkg::OP_DEC3;
              push.entry.bytes[1] = held[0];
              push.entry.bytes[2] = b;
            end
            default: begin
              push.entry.kind     = u8u16_pkg::OP_DEC4;
              push.entry.bytes[1] = held[0];
              push.entry.bytes[2] = held[1];
              push.entry.bytes[3] = b;
            end
          endcase
          lead_next = '0;
          need_next = '0;
          seen_next = '0;
        end else if (item.string_end) begin
          // string cut short: drop the lead, rescan held bytes plus this one
          if (seen == 2'd0) begin
            push.valid          = !b[7];
            push.entry.bytes[0] = b;
          end else if (!held[0][7]) begin
            push.valid          = 1'b1;
            push.entry.kind     = b[7] ? u8u16_pkg::OP_ASCII1 : u8u16_pkg::OP_ASCII2;
            push.entry.bytes[0] = held[0];
            push.entry.bytes[1] = b;
          end else if (held[0][7:5] == 3'b110) begin
            push.valid          = 1'b1;
            push.entry.kind     = u8u16_pkg::OP_DEC2;
            push.entry.bytes[0] = held[0];
            push.entry.bytes[1] = b;
          end else begin
            push.valid          = !b[7];
            push.entry.bytes[0] = b;
          end
        end else begin
          hold_en   = 1'b1;
          seen_next = seen + 2'd1;
        end
      end else begin
        push.valid          = !b[7];
        push.entry.bytes[0] = b;
        if (b_need != 2'd0 && !item.string_end) begin
          lead_next = b;
          need_next = b_need;
          seen_next = '0;
        end
      end
      if (item.string_end) begin
        lead_next = '0;
        need_next = '0;
        seen_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lead <= '0;
      need <= '0;
      seen <= '0;
    end else begin
      lead <= lead_next;
      need <= need_next;
      seen <= seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (hold_en) begin
      held[seen[0]] <= b;
    end
  end

`ifndef SYNTH
  a_idle_no_seen: assert property (@(posedge clk) disable iff (rst)
    (need == 2'd0) |-> (seen == 2'd0))
    else $error("front: held count without a pending lead");
  a_seen_below_need: assert property (@(posedge clk) disable iff (rst)
    (need != 2'd0) |-> (seen < need))
    else $error("front: held count reached the sequence length");
`endif

endmodule

FILE: sv/u8u16_queue.sv
// Small flop-based job queue between front and back.
module u8u16_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  u8u16_pkg::push_t    push,
  input  logic                pop,
  output logic                full,
  output logic                head_valid,
  output u8u16_pkg::entry_t   head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  u8u16_pkg::entry_t slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push.valid && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push.valid && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots[wr_ptr] <= push.entry;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> !full)
    else $error("queue: write into a full queue");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue: occupancy beyond depth");
`endif

endmodule

FILE: sv/u8u16_back.sv
// Back end: turns decode jobs into code units behind an output register.
module u8u16_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 head_valid,
  input  u8u16_pkg::entry_t    head,
  output logic                 pop,
  output logic                 unit_valid,
  input  logic                 unit_ready,
  output u8u16_pkg::out_item_t unit_data
);

  logic        phase;     // 1 while the second unit of a job is due
  logic        load;
  logic        two;
  logic        last;
  logic [15:0] unit0;
  logic [15:0] unit1;
  logic [20:0] cp;
  logic [15:0] hi_bits;

  assign cp      = {head.bytes[0][2:0], head.bytes[1][5:0], head.bytes[2][5:0],
                    head.bytes[3][5:0]};
  // low 16 bits of (cp - 0x10000) >> 10, wrapping for values below 0x10000
  assign hi_bits = {5'b0, cp[20:10]} - u8u16_pkg::SUPP_BASE_K;

  always_comb begin
    unit1 = '0;
    two   = 1'b0;
    case (head.kind)
      u8u16_pkg::OP_ASCII1: unit0 = {8'h00, head.bytes[0]};
      u8u16_pkg::OP_ASCII2: begin
        unit0 = {8'h00, head.bytes[0]};
        unit1 = {8'h00, head.bytes[1]};
        two   = 1'b1;
      end
      u8u16_pkg::OP_DEC2: unit0 = {5'b0, head.bytes[0][4:0], head.bytes[1][5:0]};
      u8u16_pkg::OP_DEC3: unit0 = {head.bytes[0][3:0], head.bytes[1][5:0],
                                   head.bytes[2][5:0]};
      u8u16_pkg::OP_DEC4: begin
        unit0 = u8u16_pkg::SURR_HIGH | hi_bits;
        unit1 = u8u16_pkg::SURR_LOW | {6'b0, cp[9:0]};
        two   = 1'b1;
      end
      default: unit0 = '0;
    endcase
  end

  assign load = head_valid && (!unit_valid || unit_ready);
  assign last = !two || phase;
  assign pop  = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_valid <= 1'b0;
      phase      <= 1'b0;
    end else if (load) begin
      unit_valid <= 1'b1;
      phase      <= !last;
    end else if (unit_ready) begin
      unit_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      unit_data.code_unit <= phase ? unit1 : unit0;
      unit_data.run_last  <= last;
    end
  end

`ifndef SYNTH
  a_phase_on_pair: assert property (@(posedge clk) disable iff (rst)
    phase |-> (head_valid && (head.kind == u8u16_pkg::OP_ASCII2 ||
                              head.kind == u8u16_pkg::OP_DEC4)))
    else $error("back: second-unit phase without a two-unit job at head");
`endif

endmodule

FILE: sv/utf8_to_utf16_transcoder.sv
// Top level of the UTF-8 to UTF-16 transcoder: front end, job queue, back end.
// Path: a job enters the job queue when its byte transfers, and its first code unit is
// then loaded into the output register once that is free; the low half of a pair follows.
// Throughput: one byte per cycle in while the queue has room; one code unit per
// cycle out while unit_ready is high, and bytes keep entering while a pair goes out.
// Reset: synchronous rst clears the pending sequence, empties the queue and drops the
// output register; the held continuation bytes are not cleared.
module utf8_to_utf16_transcoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  // byte channel
  input  logic                 byte_valid,
  output logic                 byte_ready,
  input  u8u16_pkg::in_item_t  byte_data,
  // code unit channel
  output logic                 unit_valid,
  input  logic                 unit_ready,
  output u8u16_pkg::out_item_t unit_data
);

  logic              accept;
  logic              full;
  logic              head_valid;
  logic              pop;
  u8u16_pkg::push_t  push;
  u8u16_pkg::entry_t head;

  // A byte transfer happens whenever the queue has room; bytes that give no unit
  // (stray continuations, lead and held bytes) never enter the queue.
  assign byte_ready = !full;
  assign accept     = byte_valid && byte_ready;

  // Front: sequence tracking and job formation, at most one job per byte.
  u8u16_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (byte_data),
    .push   (push)
  );

  // Queue: decouples byte intake from unit delivery and absorbs pair expansion.
  u8u16_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  // Back: assembles code units and surrogate halves into the output register.
  u8u16_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .unit_valid (unit_valid),
    .unit_ready (unit_ready),
    .unit_data  (unit_data)
  );

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the UTF-8 to UTF-16 transcoder.

// Predicts the code units of each accepted byte and checks the units that come out.
class utf16_scoreboard;
  logic [7:0]  lead;
  logic [1:0]  need;
  logic [1:0]  seen;
  logic [7:0]  held [2];
  logic [15:0] byte_units [$];
  u8u16_pkg::out_item_t expected_units [$];
  int errors;

  function new();
    lead = 8'h00;
    need = 2'd0;
    seen = 2'd0;
    held[0] = 8'h00;
    held[1] = 8'h00;
    errors = 0;
  endfunction

  // append one predicted unit for the byte being noted
  function void add_unit(logic [15:0] u);
    byte_units = {byte_units, u};
  endfunction

  // lead plus cnt following bytes; only the low six bits of each follower count
  function void decode(logic [7:0] ld, logic [7:0] f0, logic [7:0] f1, logic [7:0] f2,
                       int cnt);
    logic [31:0] d;
    case (cnt)
      1: add_unit({5'd0, ld[4:0], f0[5:0]});
      2: add_unit({ld[3:0], f0[5:0], f1[5:0]});
      default: begin
        // wraps when the value is below the supplementary planes
        d = {11'd0, ld[2:0], f0[5:0], f1[5:0], f2[5:0]} - 32'h0001_0000;
        add_unit(u8u16_pkg::SURR_HIGH | d[25:10]);
        add_unit(u8u16_pkg::SURR_LOW | {6'd0, d[9:0]});
      end
    endcase
  endfunction

  // string ended mid-sequence: lead is gone, the rest is read again from scratch
  function void rescan(logic [7:0] r [3], int m);
    int i;
    i = 0;
    while (i < m) begin
      if (r[i] < 8'h80) begin
        add_unit({8'h00, r[i]});
        i++;
      end else if (r[i][7:5] == 3'b110 && i + 1 < m) begin
        decode(r[i], r[i+1], 8'h00, 8'h00, 1);
        i += 2;
      end else begin
        i++;
      end
    end
  endfunction

  function void note_byte(u8u16_pkg::in_item_t item);
    logic [7:0] f [3];
    logic [7:0] b;
    logic [1:0] kind;
    u8u16_pkg::out_item_t unit;
    b = item.in_byte;
    kind = 2'd0;
    byte_units.delete();
    f[0] = held[0];
    f[1] = held[1];
    f[2] = 8'h00;
    f[seen] = b;
    if (need != 2'd0) begin
      if (int'(seen) + 1 >= int'(need)) begin
        decode(lead, f[0], f[1], f[2], int'(need));
        need = 2'd0;
      end else if (item.string_end) begin
        rescan(f, int'(seen) + 1);
      end else begin
        held[seen[0]] = b;
        seen = seen + 2'd1;
      end
    end else begin
      if (b < 8'h80) add_unit({8'h00, b});
      else if (b[7:5] == 3'b110) kind = 2'd1;
      else if (b[7:4] == 4'b1110) kind = 2'd2;
      else if (b[7:3] == 5'b11110) kind = 2'd3;
      if (kind != 2'd0 && !item.string_end) begin
        lead = b;
        need = kind;
        seen = 2'd0;
      end
    end
    if (item.string_end || need == 2'd0) begin
      lead = 8'h00;
      need = 2'd0;
      seen = 2'd0;
    end
    foreach (byte_units[i]) begin
      unit.code_unit = byte_units[i];
      unit.run_last  = (i == byte_units.size() - 1);
      expected_units = {expected_units, unit};
    end
  endfunction

  function void check_unit(u8u16_pkg::out_item_t got);
    u8u16_pkg::out_item_t want;
    if (expected_units.size() == 0) begin
      $error("code_unit: expected none, got %h", got.code_unit);
      errors++;
      return;
    end
    want = expected_units.pop_front();
    if (got.code_unit !== want.code_unit) begin
      $error("code_unit: expected %h, got %h", want.code_unit, got.code_unit);
      errors++;
    end
    if (got.run_last !== want.run_last) begin
      $error("run_last: expected %b, got %b", want.run_last, got.run_last);
      errors++;
    end
  endfunction
endclass

module tb;

  // cycles without any transfer on either channel before the run is declared hung
  localparam int STALL_LIMIT = 1000;
  // random bytes sent in each idling phase
  localparam int PHASE_BYTES = 400;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 byte_valid = 1'b0;
  logic                 byte_ready;
  u8u16_pkg::in_item_t  byte_data = '0;
  logic                 unit_valid;
  logic                 unit_ready = 1'b0;
  u8u16_pkg::out_item_t unit_data;

  // idling percentages of the sender and the receiver, changed per phase
  int unsigned src_idle_pct  = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned src_idle_tbl  [4] = '{0, 49, 0, 22};
  int unsigned sink_stall_tbl[4] = '{0, 0, 49, 22};

  int phase_bytes = 0;
  int idle_cycles = 0;

  utf16_scoreboard sb = new();

  utf8_to_utf16_transcoder u_dut (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(byte_valid),
    .byte_ready(byte_ready),
    .byte_data (byte_data),
    .unit_valid(unit_valid),
    .unit_ready(unit_ready),
    .unit_data (unit_data)
  );

  always #5 clk = ~clk;

  // Receiver: ready drops at random, independent of whether a unit is offered,
  // so stalls land on both halves of a surrogate pair as well as single units.
  always @(posedge clk) begin
    unit_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Output monitor. Values read here are the ones from before the edge,
  // so the transfer condition matches what the block saw.
  always @(posedge clk) begin
    if (!rst && unit_valid && unit_ready) sb.check_unit(unit_data);
  end

  // Watchdog: any transfer on either side restarts the count.
  always @(posedge clk) begin
    if (rst || (byte_valid && byte_ready) || (unit_valid && unit_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  // One byte transfer. Optional idle cycles first (valid low), then valid is held
  // with a steady payload until ready is seen at an edge.
  task automatic send_byte(input logic [7:0] b, input logic last);
    u8u16_pkg::in_item_t item;
    item.in_byte    = b;
    item.string_end = last;
    while ($urandom_range(99) < src_idle_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_data  <= item;
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
    sb.note_byte(item);
    phase_bytes++;
  endtask

  // Short directed strings: field extremes, each sequence length, surrogates,
  // a wrapped four-byte value, stray bytes, and strings that end early.
  task automatic run_directed();
    // plain ASCII at both ends of its range
    send_byte(8'h00, 1'b0); send_byte(8'h7F, 1'b1);
    // two-byte sequences, smallest lead and largest value
    send_byte(8'hC2, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'hDF, 1'b0); send_byte(8'hBF, 1'b1);
    // three-byte sequence
    send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b0); send_byte(8'hAC, 1'b1);
    // highest code point, then an overlong four-byte value that wraps
    send_byte(8'hF4, 1'b0); send_byte(8'h8F, 1'b0);
    send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0);
    send_byte(8'hF0, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0); send_byte(8'h80, 1'b1);
    // stray continuation byte and bytes that can never start a sequence
    send_byte(8'h80, 1'b0); send_byte(8'hF8, 1'b0); send_byte(8'hFF, 1'b1);
    // lead byte that carries the end flag
    send_byte(8'hC3, 1'b1);
    // string ends mid-sequence: ASCII is recovered from the leftover
    send_byte(8'hE0, 1'b0); send_byte(8'h41, 1'b1);
    // string ends mid-sequence: a two-byte sequence is recovered from the leftover
    send_byte(8'hF0, 1'b0); send_byte(8'hC3, 1'b0); send_byte(8'hA9, 1'b1);
  endtask

  // One random string of a few characters. Most characters are well formed with
  // random payload bits; some followers are arbitrary bytes, some characters are
  // noise, and now and then the string is cut inside a multi-byte character.
  task automatic random_string();
    logic [7:0] bytes_q [$];
    logic [7:0] ld;
    int nchars, len, cut;
    bit cut_short;
    cut_short = 1'b0;
    nchars = int'($urandom_range(1, 6));
    for (int c = 0; c < nchars && !cut_short; c++) begin
      case ($urandom_range(9))
        0, 1, 2: begin len = 0; ld = 8'($urandom_range(127)); end
        3, 4:    begin len = 1; ld = 8'hC0 | 8'($urandom_range(31)); end
        5, 6:    begin len = 2; ld = 8'hE0 | 8'($urandom_range(15)); end
        7, 8:    begin len = 3; ld = 8'hF0 | 8'($urandom_range(7)); end
        default: begin len = 0; ld = 8'($urandom_range(255)); end
      endcase
      bytes_q = {bytes_q, ld};
      cut = len;
      if (len != 0 && $urandom_range(9) == 0) begin
        cut = int'($urandom_range(len - 1));
        cut_short = 1'b1;
      end
      for (int k = 0; k < cut; k++) begin
        if ($urandom_range(9) == 0) bytes_q = {bytes_q, 8'($urandom_range(255))};
        else bytes_q = {bytes_q, 8'h80 | 8'($urandom_range(63))};
      end
    end
    foreach (bytes_q[i]) send_byte(bytes_q[i], i == bytes_q.size() - 1);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Four idling phases: none, sender only, receiver only, both.
    for (int p = 0; p < 4; p++) begin
      src_idle_pct   = src_idle_tbl[p];
      sink_stall_pct = sink_stall_tbl[p];
      if (p == 0) run_directed();
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) random_string();
    end
    byte_valid <= 1'b0;
    // Drain; the watchdog bounds this wait.
    while (sb.expected_units.size() != 0) @(posedge clk);
    // A few more cycles to catch any unit that should not be there.
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule
